@@ rtl/shuffled_minimal_standard_rng_defines.svh @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard RNG assertion macros
// Shared property wrappers for the checker of the random generator block.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_DEFINES_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_DEFINES_SVH

// Property checked on every rising edge while reset is released.
`define SMSR_ASSERT_ON(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SMSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/smsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard RNG package
// Constants, controller states and control types shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smsr_pkg;

    // Shuffle table depth, legal range 2 to 256.
    localparam int TABLE_DEPTH  = 32;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);

    localparam int VALUE_W      = 31;
    localparam int FRACTION_W   = 24;
    localparam int FRACTION_SHIFT = 7;
    localparam int MUL_W        = 15;
    localparam int PROD_W       = VALUE_W + MUL_W;

    localparam logic [VALUE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
    localparam logic [MUL_W-1:0]   LEHMER_MUL = 15'd16807;

    localparam int WARMUP_STEPS = 8;
    localparam int WARM_W       = $clog2(WARMUP_STEPS);
    localparam int CNT_W        = (IDX_W > WARM_W) ? IDX_W : WARM_W;

    // Slot select divides the last output by SLOT_DIVISOR. The quotient is
    // estimated with a small reciprocal and then corrected by one compare.
    localparam longint unsigned SLOT_DIVISOR = 64'd1 + 64'd2147483646 / TABLE_DEPTH;
    localparam longint unsigned SLOT_RECIP   = (64'd1 << 32) / SLOT_DIVISOR;
    localparam int RECIP_W  = $clog2(SLOT_RECIP + 64'd1);
    localparam int QPROD_W  = VALUE_W + RECIP_W;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WARM_MUL,
        ST_WARM_FOLD,
        ST_FILL_MUL,
        ST_FILL_FOLD,
        ST_DRAW_MUL,
        ST_DRAW_FOLD,
        ST_DRAW_READ,
        ST_DRAW_COMMIT
    } state_t;

    typedef struct packed {
        logic             load_x;
        logic             use_seed;
        logic             mul_en;
        logic             fold_en;
        logic             fill_wr;
        logic             fill_last;
        logic [IDX_W-1:0] fill_addr;
        logic             est_en;
        logic             slot_en;
        logic             read_en;
        logic             commit;
    } cmd_t;

    typedef struct packed {
        logic last_zero;
        logic out_free;
    } status_t;

    // Lower edge of slot k, that is k times the slot divisor.
    function automatic logic [31:0] slot_threshold(input logic [IDX_W:0] k);
        slot_threshold = 32'(k) * 32'(SLOT_DIVISOR);
    endfunction

endpackage

@@ rtl/smsr_datapath.sv @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard RNG datapath
// Lehmer step, slot select, shuffle memory and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smsr_datapath
    import smsr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    input  logic [VALUE_W-1:0]   seed,
    input  logic                 m_tready,
    output status_t              status,
    output logic                 m_tvalid,
    output logic [M_DATA_W-1:0]  m_tdata
);

    logic [VALUE_W-1:0] x_reg, x_next;
    logic [VALUE_W-1:0] last_reg, last_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [IDX_W-1:0]   est_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [VALUE_W-1:0] rd_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_valid_reg, out_valid_next;

    logic [VALUE_W-1:0] shuffle_mem [TABLE_DEPTH];

    logic [31:0]        fold_sum;
    logic [VALUE_W-1:0] folded;
    logic [VALUE_W-1:0] seed_norm;
    logic [QPROD_W-1:0] qprod;
    logic [IDX_W:0]     est_plus;
    logic [IDX_W-1:0]   slot_calc;

    // Modulus 2^31-1: add the high part back onto the low part.
    assign fold_sum = 32'(prod_reg[VALUE_W-1:0]) + 32'(prod_reg[PROD_W-1:VALUE_W]);
    assign folded   = (fold_sum >= 32'(LEHMER_MOD)) ? 31'(fold_sum - 32'(LEHMER_MOD))
                                                     : fold_sum[VALUE_W-1:0];

    assign seed_norm = (seed == '0 || seed == LEHMER_MOD) ? 31'd1 : seed;

    assign qprod     = QPROD_W'(last_reg) * QPROD_W'(SLOT_RECIP);
    assign est_plus  = (IDX_W+1)'(est_reg) + 1'b1;
    // The estimate is low by at most one; the quotient stays below the depth.
    assign slot_calc = (32'(last_reg) >= slot_threshold(est_plus)) ? est_plus[IDX_W-1:0]
                                                                  : est_reg;

    always_comb begin
        x_next = x_reg;
        if (cmd.load_x) begin
            x_next = cmd.use_seed ? seed_norm : 31'd1;
        end else if (cmd.fold_en) begin
            x_next = folded;
        end
    end

    always_comb begin
        last_next = last_reg;
        if (cmd.fill_last) begin
            last_next = folded;
        end else if (cmd.commit) begin
            last_next = rd_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg         <= 31'd1;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            x_reg         <= x_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'(LEHMER_MUL);
        end
        if (cmd.est_en) begin
            est_reg <= qprod[32 +: IDX_W];
        end
        if (cmd.slot_en) begin
            slot_reg <= slot_calc;
        end
        if (cmd.commit) begin
            out_value_reg <= rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_wr) begin
            shuffle_mem[cmd.fill_addr] <= folded;
        end else if (cmd.commit) begin
            shuffle_mem[slot_reg] <= x_reg;
        end
        if (cmd.read_en) begin
            rd_reg <= shuffle_mem[slot_reg];
        end
    end

    assign status.last_zero = (last_reg == '0);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg[VALUE_W-1:FRACTION_SHIFT], out_value_reg};

endmodule

@@ rtl/smsr_controller.sv @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard RNG controller
// Sequences warm-up, table fill and draw steps of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smsr_controller
    import smsr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     reseed,
    input  status_t  status,
    output logic     s_tready,
    output cmd_t     cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.fill_addr = cnt_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (reseed || status.last_zero) begin
                        cmd.load_x   = 1'b1;
                        cmd.use_seed = reseed;
                        cnt_next     = CNT_W'(WARMUP_STEPS - 1);
                        state_next   = ST_WARM_MUL;
                    end else begin
                        state_next   = ST_DRAW_MUL;
                    end
                end
            end
            ST_WARM_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_WARM_FOLD;
            end
            ST_WARM_FOLD: begin
                cmd.fold_en = 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next   = CNT_W'(TABLE_DEPTH - 1);
                    state_next = ST_FILL_MUL;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_WARM_MUL;
                end
            end
            ST_FILL_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_FILL_FOLD;
            end
            ST_FILL_FOLD: begin
                cmd.fold_en = 1'b1;
                cmd.fill_wr = 1'b1;
                if (cnt_reg == '0) begin
                    // Slot zero is the last filled and seeds the first slot pick.
                    cmd.fill_last = 1'b1;
                    state_next    = ST_DRAW_MUL;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_FILL_MUL;
                end
            end
            ST_DRAW_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.est_en = 1'b1;
                state_next = ST_DRAW_FOLD;
            end
            ST_DRAW_FOLD: begin
                cmd.fold_en = 1'b1;
                cmd.slot_en = 1'b1;
                state_next  = ST_DRAW_READ;
            end
            ST_DRAW_READ: begin
                cmd.read_en = 1'b1;
                state_next  = ST_DRAW_COMMIT;
            end
            ST_DRAW_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/shuffled_minimal_standard_rng.sv @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard random generator
// Park-Miller generator with a Bays-Durham shuffle table on stream ports.
// ----------------------------------------------------------------------------
// Each input beat requests one uniform draw and yields exactly one output
// beat. A draw finishes before the block accepts the next beat: the Lehmer
// step is a constant multiply followed by a Mersenne fold in the next
// cycle, and the shuffle memory has a registered read, so a draw runs
// multiply, fold, read and commit in turn. A reseed beat, and the first
// draw after reset, first prime the table with 8 discarded steps and one
// step for each table entry, each step a multiply and then a fold. The
// result sits in an output register, so the next beat is taken while a
// result still waits; only a second result stalls until the first is taken.
// The table needs no clearing after reset because it is always filled
// before it is read.
`timescale 1ns / 1ps

module shuffled_minimal_standard_rng
    import smsr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,  // [30:0] seed, [31] zero pad
    input  logic [0:0]           s_tuser,  // [0] operation: 1 reseed, 0 draw
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata   // [30:0] value, [54:31] fraction, [55] zero pad
);

    cmd_t    cmd;
    status_t status;

    // The controller owns the sequencing and the warm-up and fill counter.
    smsr_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .reseed   (s_tuser[0]),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // The datapath holds the generator state, the shuffle memory and the
    // output register; the seed is only sampled in the accepting cycle.
    smsr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .seed     (s_tdata[VALUE_W-1:0]),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/smsr_checker.sv @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard RNG checker
// Port-level properties of the random generator, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shuffled_minimal_standard_rng_defines.svh"

module smsr_checker
    import smsr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    `SMSR_ASSERT_ON(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SMSR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid right after reset")
    `SMSR_ASSERT_ON(a_value_range, m_tvalid |-> m_tdata[30:0] != 31'd0 && m_tdata[30:0] != 31'h7FFF_FFFF, "value out of range")
    `SMSR_ASSERT_ON(a_fraction, m_tvalid |-> m_tdata[54:31] == m_tdata[30:7] && !m_tdata[55], "fraction differs from value")
    `SMSR_ASSERT_ON(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while a draw runs")

endmodule

bind shuffled_minimal_standard_rng smsr_checker u_smsr_checker (.*);

@@ test/shuffled_minimal_standard_rng_tb.sv @@
// ----------------------------------------------------------------------------
// Shuffled minimal standard RNG testbench
// Stream-level test of the Park-Miller generator with its shuffle table.
// ----------------------------------------------------------------------------
// Each accepted request beat goes through a software copy of the generator.
// That copy holds the Lehmer state, the last drawn value and the shuffle
// table. The beat it predicts is queued and compared with the next result
// beat. The directed tests cover a draw before any reseed, the zero seed, a
// seed equal to the modulus and the extreme seeds. Three runs of random
// traffic follow, two with idle cycles on both sides. One stretch stalls the
// result channel long enough to back up the request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shuffled_minimal_standard_rng_tb
    import smsr_pkg::*;
;

    localparam bit OP_DRAW   = 1'b0;
    localparam bit OP_RESEED = 1'b1;

    localparam longint unsigned MODULUS    = 64'd2147483647;
    localparam longint unsigned MULTIPLIER = 64'd16807;
    localparam longint unsigned SLOT_SPAN  = 64'd1 + (MODULUS - 64'd1) / TABLE_DEPTH;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [FRACTION_W-1:0] fraction;
    } draw_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Software copy of the generator.
    logic [VALUE_W-1:0] gen_state;
    logic [VALUE_W-1:0] last_drawn;
    logic [VALUE_W-1:0] shuffle_slots [TABLE_DEPTH];

    draw_result_t expected_draws [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int n_draws = 0;
    int n_reseeds = 0;
    int n_results = 0;
    int n_errors = 0;
    int cycle_count = 0;

    shuffled_minimal_standard_rng uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Generator prediction
    // ------------------------------------------------------------------
    function automatic logic [VALUE_W-1:0] lehmer_step(input logic [VALUE_W-1:0] x);
        longint unsigned prod;
        prod = longint'(x) * MULTIPLIER;
        return VALUE_W'(prod % MODULUS);
    endfunction

    // Warm up from a seed and refill the table, top slot first.
    task automatic prime_shuffle(input logic [VALUE_W-1:0] seed);
        logic [VALUE_W-1:0] x;
        x = VALUE_W'(longint'(seed) % MODULUS);
        if (x == '0) begin
            x = 31'd1;
        end
        for (int n = 0; n < WARMUP_STEPS; n++) begin
            x = lehmer_step(x);
        end
        for (int n = TABLE_DEPTH - 1; n >= 0; n--) begin
            x = lehmer_step(x);
            shuffle_slots[n] = x;
        end
        gen_state  = x;
        last_drawn = shuffle_slots[0];
    endtask

    task automatic predict_draw(input bit op, input logic [VALUE_W-1:0] seed);
        int unsigned  slot;
        draw_result_t res;
        if (op == OP_RESEED) begin
            prime_shuffle(seed);
        end else if (last_drawn == '0) begin
            // Table never primed: the block starts from seed one.
            prime_shuffle(31'd1);
        end
        gen_state  = lehmer_step(gen_state);
        slot       = int'((longint'(last_drawn) / SLOT_SPAN) % TABLE_DEPTH);
        last_drawn = shuffle_slots[slot];
        shuffle_slots[slot] = gen_state;
        res.value    = last_drawn;
        res.fraction = FRACTION_W'(last_drawn >> FRACTION_SHIFT);
        expected_draws.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Request side: one beat per call. Valid stays high after acceptance so
    // back-to-back beats need no second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_request(input bit op, input logic [VALUE_W-1:0] seed);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(1));
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - VALUE_W){1'b0}}, seed};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predict_draw(op, seed);
        if (op == OP_RESEED) begin
            n_reseeds++;
        end else begin
            n_draws++;
        end
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_draws.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side. A stall request loads a long hold-off that is counted
    // down here, one cycle at a time.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : ready_driver
        static int hold_left = 0;
        static int stalls_seen = 0;
        if (stalls_seen != stall_requests) begin
            stalls_seen = stall_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_checker
        draw_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_draws.size() == 0) begin
                $error("result beat with no draw pending: tdata=%h", m_tdata);
                n_errors++;
            end else begin
                want = expected_draws.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value,
                           m_tdata[VALUE_W-1:0]);
                    n_errors++;
                end
                if (m_tdata[VALUE_W +: FRACTION_W] !== want.fraction) begin
                    $error("fraction: expected %h, got %h", want.fraction,
                           m_tdata[VALUE_W +: FRACTION_W]);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d draws outstanding",
                     cycle_count, expected_draws.size());
            $display("shuffled_minimal_standard_rng test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The first draw after reset primes the table from seed one. The seed
    // field is ignored on a draw, so it carries junk here.
    task automatic test_unprimed_draw();
        send_request(OP_DRAW, 31'h7FFF_FFFF);
        send_request(OP_DRAW, 31'h1234_5678);
        send_request(OP_DRAW, '0);
        wait_for_results();
    endtask

    task automatic test_seed_edges();
        // A zero seed and a seed equal to the modulus both fall back to one.
        send_request(OP_RESEED, '0);
        send_request(OP_DRAW, '0);
        send_request(OP_RESEED, 31'h7FFF_FFFF);
        send_request(OP_DRAW, 31'h7FFF_FFFF);
        send_request(OP_RESEED, 31'd1);
        send_request(OP_DRAW, '0);
        send_request(OP_RESEED, 31'd2147483646);
        send_request(OP_DRAW, '0);
        send_request(OP_DRAW, 31'h5555_5555);
        send_request(OP_RESEED, 31'h5555_5555);
        send_request(OP_RESEED, 31'h2AAA_AAAA);
        send_request(OP_DRAW, 31'h2AAA_AAAA);
        send_request(OP_RESEED, 31'd16807);
        for (int n = 0; n < 6; n++) begin
            send_request(OP_DRAW, '0);
        end
        wait_for_results();
    endtask

    // Hold the result channel off while requests keep coming, so the
    // output register fills and the request side stalls.
    task automatic test_output_stall();
        stall_requests++;
        for (int n = 0; n < 12; n++) begin
            send_request(OP_DRAW, VALUE_W'($urandom));
        end
        wait_for_results();
    endtask

    // Mostly draws; reseeds are rare since each one refills the table.
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        bit                 op;
        logic [VALUE_W-1:0] seed;
        int                 pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            op   = ($urandom_range(99) < 3) ? OP_RESEED : OP_DRAW;
            pick = $urandom_range(19);
            if (pick == 0) begin
                seed = '0;
            end else if (pick == 1) begin
                seed = 31'h7FFF_FFFF;
            end else if (pick == 2) begin
                seed = 31'd2147483646;
            end else begin
                seed = VALUE_W'($urandom);
            end
            send_request(op, seed);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 63;
        test_unprimed_draw();
        test_seed_edges();
        test_output_stall();

        test_random_traffic(550, 7, 63);
        test_random_traffic(550, 63, 7);
        test_random_traffic(550, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d draws and %0d reseeds, %0d result beats checked",
                 n_draws, n_reseeds, n_results);
        $display("seed edges, unprimed draws, long output stall and three idle mixes");
        if (n_errors == 0 && expected_draws.size() == 0) begin
            $display("shuffled_minimal_standard_rng test passed");
        end else begin
            $display("shuffled_minimal_standard_rng test failed");
        end
        $finish;
    end

endmodule
